// ----- sv/lqpn_pkg.sv -----
package lqpn_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_APPLY = 2'd1,
    ACT_GET   = 2'd2
  } act_t;

  localparam logic [7:0] PID_BAUD      = 8'h01;
  localparam logic [7:0] PID_LINK_DISC = 8'h08;
  localparam logic [7:0] PID_MAX_TURN  = 8'h82;
  localparam logic [7:0] PID_DATA_SIZE = 8'h83;
  localparam logic [7:0] PID_WINDOW    = 8'h84;
  localparam logic [7:0] PID_ADD_BOFS  = 8'h85;
  localparam logic [7:0] PID_MIN_TURN  = 8'h86;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BAUD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TURN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_DISC = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_BOFS  = 3'd6;

  localparam logic [15:0] RST_BAUD      = 16'h01ff;
  localparam logic [7:0]  RST_WINDOW    = 8'h7f;
  localparam logic [7:0]  RST_MIN_TURN  = 8'hff;
  localparam logic [7:0]  RST_MAX_TURN  = 8'h0f;
  localparam logic [7:0]  RST_DATA_SIZE = 8'h3f;
  localparam logic [7:0]  RST_LINK_DISC = 8'hff;
  localparam logic [7:0]  RST_ADD_BOFS  = 8'hff;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_CLAMPED = 2'd3;

  localparam logic [3:0] BAUD_LEN     = 4'd10;
  localparam logic [3:0] DATA_LEN     = 4'd6;
  localparam logic [3:0] MAX_TURN_LEN = 4'd4;

  typedef struct packed {
    act_t        action;
    logic [7:0]  param_id;
    logic [15:0] param_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] param_bits_out;
    logic [23:0] baud_rate_bps;
    logic [11:0] data_size_bytes;
    logic [3:0]  window_frames;
    logic [13:0] min_turn_us;
    logic [8:0]  max_turn_ms;
    logic [5:0]  link_disc_s;
    logic [5:0]  extra_bofs;
  } rsp_t;

  typedef struct packed {
    logic [15:0] baud;
    logic [7:0]  window;
    logic [7:0]  min_turn;
    logic [7:0]  max_turn;
    logic [7:0]  dsize;
    logic [7:0]  ldisc;
    logic [7:0]  xbofs;
  } loc_t;

  typedef struct packed {
    logic [15:0] rx_baud;
    logic [7:0]  rx_link_disc;
    logic [15:0] tx_baud;
    logic [7:0]  tx_link_disc;
    logic [7:0]  tx_window;
    logic [7:0]  tx_min_turn;
    logic [7:0]  tx_max_turn;
    logic [7:0]  tx_data_size;
    logic [7:0]  tx_add_bofs;
  } mask_t;

  typedef struct packed {
    logic        unknown;
    logic [15:0] bits_out;
  } upd_info_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } enc_t;

  function automatic enc_t top_bit(input logic [15:0] m);
    enc_t r;
    r.hit = 1'b0;
    r.idx = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (m[i]) begin
        r.hit = 1'b1;
        r.idx = 4'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [23:0] baud_lut(input logic [3:0] idx);
    logic [23:0] v;
    unique case (idx)
      4'd0:    v = 24'd2400;
      4'd1:    v = 24'd9600;
      4'd2:    v = 24'd19200;
      4'd3:    v = 24'd38400;
      4'd4:    v = 24'd57600;
      4'd5:    v = 24'd115200;
      4'd6:    v = 24'd576000;
      4'd7:    v = 24'd1152000;
      4'd8:    v = 24'd4000000;
      default: v = 24'd16000000;
    endcase
    return v;
  endfunction

  function automatic logic [11:0] dsize_lut(input logic [2:0] idx);
    logic [11:0] v;
    unique case (idx)
      3'd0:    v = 12'd64;
      3'd1:    v = 12'd128;
      3'd2:    v = 12'd256;
      3'd3:    v = 12'd512;
      3'd4:    v = 12'd1024;
      default: v = 12'd2048;
    endcase
    return v;
  endfunction

  function automatic logic [13:0] min_turn(input logic [2:0] idx);
    logic [13:0] v;
    unique case (idx)
      3'd0:    v = 14'd10000;
      3'd1:    v = 14'd5000;
      3'd2:    v = 14'd1000;
      3'd3:    v = 14'd500;
      3'd4:    v = 14'd100;
      3'd5:    v = 14'd50;
      3'd6:    v = 14'd10;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] max_turn(input logic [2:0] idx);
    logic [8:0] v;
    unique case (idx)
      3'd0:    v = 9'd500;
      3'd1:    v = 9'd250;
      3'd2:    v = 9'd100;
      default: v = 9'd50;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] ldisc_lut(input logic [2:0] idx);
    logic [5:0] v;
    unique case (idx)
      3'd0:    v = 6'd3;
      3'd1:    v = 6'd8;
      3'd2:    v = 6'd12;
      3'd3:    v = 6'd16;
      3'd4:    v = 6'd20;
      3'd5:    v = 6'd25;
      3'd6:    v = 6'd30;
      default: v = 6'd40;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] xbofs_lut(input logic [2:0] idx);
    logic [5:0] v;
    unique case (idx)
      3'd0:    v = 6'd48;
      3'd1:    v = 6'd24;
      3'd2:    v = 6'd12;
      3'd3:    v = 6'd5;
      3'd4:    v = 6'd3;
      3'd5:    v = 6'd2;
      3'd6:    v = 6'd1;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/lqpn_update.sv -----
module lqpn_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  lqpn_pkg::req_t      req,
  input  lqpn_pkg::loc_t      loc,
  output lqpn_pkg::mask_t     masks_nxt,
  output lqpn_pkg::upd_info_t info
);
  import lqpn_pkg::*;

  mask_t masks_r;
  mask_t upd;
  logic [7:0] b8;

  assign b8 = req.param_value[7:0];

  always_comb begin
    upd = masks_r;
    info.unknown = 1'b0;
    info.bits_out = 16'd0;
    unique case (req.action)
      ACT_START: begin
        upd.rx_baud      = loc.baud;
        upd.tx_baud      = loc.baud;
        upd.rx_link_disc = loc.ldisc;
        upd.tx_link_disc = loc.ldisc;
        upd.tx_window    = loc.window;
        upd.tx_min_turn  = loc.min_turn;
        upd.tx_max_turn  = loc.max_turn;
        upd.tx_data_size = loc.dsize;
        upd.tx_add_bofs  = loc.xbofs;
      end
      ACT_APPLY: begin
        unique case (req.param_id)
          PID_BAUD: begin
            upd.rx_baud = req.param_value & masks_r.rx_baud;
            upd.tx_baud = req.param_value & masks_r.rx_baud;
          end
          PID_LINK_DISC: begin
            upd.rx_link_disc = b8 & masks_r.rx_link_disc;
            upd.tx_link_disc = b8 & masks_r.rx_link_disc;
          end
          PID_MAX_TURN:  upd.tx_max_turn  = b8;
          PID_DATA_SIZE: upd.tx_data_size = b8;
          PID_WINDOW:    upd.tx_window    = b8;
          PID_ADD_BOFS:  upd.tx_add_bofs  = b8;
          PID_MIN_TURN:  upd.tx_min_turn  = b8;
          default:       info.unknown = 1'b1;
        endcase
      end
      ACT_GET: begin
        unique case (req.param_id)
          PID_BAUD:      info.bits_out = masks_r.rx_baud;
          PID_LINK_DISC: info.bits_out = {8'd0, masks_r.rx_link_disc};
          PID_MAX_TURN:  info.bits_out = {8'd0, loc.max_turn};
          PID_DATA_SIZE: info.bits_out = {8'd0, loc.dsize};
          PID_WINDOW:    info.bits_out = {8'd0, loc.window};
          PID_ADD_BOFS:  info.bits_out = {8'd0, loc.xbofs};
          PID_MIN_TURN:  info.bits_out = {8'd0, loc.min_turn};
          default:       info.unknown = 1'b1;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign masks_nxt = upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r.rx_baud      <= RST_BAUD;
      masks_r.tx_baud      <= RST_BAUD;
      masks_r.rx_link_disc <= RST_LINK_DISC;
      masks_r.tx_link_disc <= RST_LINK_DISC;
      masks_r.tx_window    <= RST_WINDOW;
      masks_r.tx_min_turn  <= RST_MIN_TURN;
      masks_r.tx_max_turn  <= RST_MAX_TURN;
      masks_r.tx_data_size <= RST_DATA_SIZE;
      masks_r.tx_add_bofs  <= RST_ADD_BOFS;
    end else if (fire) begin
      masks_r <= upd;
    end
  end

endmodule

// ----- sv/lqpn_encode.sv -----
module lqpn_encode (
  input  lqpn_pkg::mask_t     masks,
  input  lqpn_pkg::upd_info_t info,
  output lqpn_pkg::rsp_t      rsp
);
  import lqpn_pkg::*;

  enc_t e_baud, e_data, e_win, e_min, e_max, e_disc, e_bofs;
  logic any_empty, any_clamped;

  assign e_baud = top_bit(masks.tx_baud);
  assign e_data = top_bit({8'd0, masks.tx_data_size});
  assign e_win  = top_bit({8'd0, masks.tx_window});
  assign e_min  = top_bit({8'd0, masks.tx_min_turn});
  assign e_max  = top_bit({8'd0, masks.tx_max_turn});
  assign e_disc = top_bit({8'd0, masks.tx_link_disc});
  assign e_bofs = top_bit({8'd0, masks.tx_add_bofs});

  assign any_empty = !e_baud.hit || !e_data.hit || !e_win.hit || !e_min.hit ||
                     !e_max.hit || !e_disc.hit || !e_bofs.hit;

  assign any_clamped = (e_baud.hit && e_baud.idx >= BAUD_LEN) ||
                       (e_data.hit && e_data.idx >= DATA_LEN) ||
                       (e_max.hit && e_max.idx >= MAX_TURN_LEN);

  always_comb begin
    rsp.param_bits_out  = info.bits_out;
    rsp.baud_rate_bps   = e_baud.hit ? baud_lut(e_baud.idx) : 24'd0;
    rsp.data_size_bytes = e_data.hit ? dsize_lut(e_data.idx[2:0]) : 12'd0;
    rsp.window_frames   = e_win.hit ? e_win.idx + 4'd1 : 4'd0;
    rsp.min_turn_us     = e_min.hit ? min_turn(e_min.idx[2:0]) : 14'd0;
    rsp.max_turn_ms     = e_max.hit ? max_turn(e_max.idx[2:0]) : 9'd0;
    rsp.link_disc_s     = e_disc.hit ? ldisc_lut(e_disc.idx[2:0]) : 6'd0;
    rsp.extra_bofs      = e_bofs.hit ? xbofs_lut(e_bofs.idx[2:0]) : 6'd0;
    priority if (info.unknown) begin
      rsp.status = ST_UNKNOWN;
    end else if (any_empty) begin
      rsp.status = ST_EMPTY;
    end else if (any_clamped) begin
      rsp.status = ST_CLAMPED;
    end else begin
      rsp.status = ST_OK;
    end
  end

endmodule

// ----- sv/link_qos_param_negotiator.sv -----
// Link QoS parameter negotiator.
// Input channel (in_valid / in_stall / in_data) takes one request: start,
// apply a peer parameter, or get a parameter mask. Each request yields
// exactly one result on the output channel (out_valid / out_stall /
// out_data) carrying status, the mask returned by a get, and the values
// looked up from the negotiated transmit masks after the request's update.
// The cfg_ port writes the local capability masks, one per cycle with
// cfg_we; write only while no request is in flight.
// A request that is accepted passes through the input register and then
// the result register before its result can be taken. Throughput: one
// request per cycle while out_stall holds no result; the mask update,
// priority encoders and value tables sit in one stage between the input
// and result registers.
// Reset loads the local masks and the negotiated masks with their default
// capability sets and empties both registers.
// When out_stall holds a result, the input register still takes one more
// request; then in_stall rises until the result is taken.
module link_qos_param_negotiator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lqpn_pkg::req_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lqpn_pkg::rsp_t                   out_data,
  input  logic                             cfg_we,
  input  logic [lqpn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lqpn_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lqpn_pkg::*;

  loc_t      loc_r;
  logic      req_valid_r;
  req_t      req_r;
  logic      out_valid_r;
  rsp_t      out_data_r;
  logic      advance;
  logic      accept;
  mask_t     masks_nxt;
  upd_info_t info;
  rsp_t      rsp;

  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r.baud     <= RST_BAUD;
      loc_r.window   <= RST_WINDOW;
      loc_r.min_turn <= RST_MIN_TURN;
      loc_r.max_turn <= RST_MAX_TURN;
      loc_r.dsize    <= RST_DATA_SIZE;
      loc_r.ldisc    <= RST_LINK_DISC;
      loc_r.xbofs    <= RST_ADD_BOFS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAUD:      loc_r.baud     <= cfg_wdata;
        REG_WINDOW:    loc_r.window   <= cfg_wdata[7:0];
        REG_MIN_TURN:  loc_r.min_turn <= cfg_wdata[7:0];
        REG_MAX_TURN:  loc_r.max_turn <= cfg_wdata[7:0];
        REG_DATA_SIZE: loc_r.dsize    <= cfg_wdata[7:0];
        REG_LINK_DISC: loc_r.ldisc    <= cfg_wdata[7:0];
        REG_ADD_BOFS:  loc_r.xbofs    <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (accept) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
  end

  lqpn_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .req       (req_r),
    .loc       (loc_r),
    .masks_nxt (masks_nxt),
    .info      (info)
  );

  lqpn_encode u_encode (
    .masks (masks_nxt),
    .info  (info),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- dv/link_qos_param_negotiator_test.sv -----
`timescale 1ns / 100ps

module link_qos_param_negotiator_test;
  import lqpn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 172;
  localparam int STUCK_LIMIT = 3000;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  link_qos_param_negotiator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int unsigned baud_tab [10] = '{2400, 9600, 19200, 38400, 57600, 115200,
                                 576000, 1152000, 4000000, 16000000};
  int unsigned data_tab [6] = '{64, 128, 256, 512, 1024, 2048};
  int unsigned min_turn_tab [8] = '{10000, 5000, 1000, 500, 100, 50, 10, 0};
  int unsigned max_turn_tab [4] = '{500, 250, 100, 50};
  int unsigned disc_tab [8] = '{3, 8, 12, 16, 20, 25, 30, 40};
  int unsigned bofs_tab [8] = '{48, 24, 12, 5, 3, 2, 1, 0};

  logic [7:0] known_ids [7] = '{PID_BAUD, PID_LINK_DISC, PID_MAX_TURN, PID_DATA_SIZE,
                                PID_WINDOW, PID_ADD_BOFS, PID_MIN_TURN};

  row_t dir_tab [25] = '{
    '{'{ACT_START, 8'h00, 16'h0000}, 1'b1,
      '{ST_OK, 16'h0000, 24'd4000000, 12'd2048, 4'd7, 14'd0, 9'd50, 6'd40, 6'd0}},
    '{'{ACT_GET, PID_BAUD, 16'h0000}, 1'b1,
      '{ST_OK, 16'h01ff, 24'd4000000, 12'd2048, 4'd7, 14'd0, 9'd50, 6'd40, 6'd0}},
    '{'{ACT_GET, 8'h00, 16'hffff}, 1'b1,
      '{ST_UNKNOWN, 16'h0000, 24'd4000000, 12'd2048, 4'd7, 14'd0, 9'd50, 6'd40, 6'd0}},
    '{'{ACT_APPLY, 8'hff, 16'hffff}, 1'b1,
      '{ST_UNKNOWN, 16'h0000, 24'd4000000, 12'd2048, 4'd7, 14'd0, 9'd50, 6'd40, 6'd0}},
    '{'{ACT_APPLY, PID_BAUD, 16'hffff}, 1'b1,
      '{ST_OK, 16'h0000, 24'd4000000, 12'd2048, 4'd7, 14'd0, 9'd50, 6'd40, 6'd0}},
    '{'{ACT_APPLY, PID_MAX_TURN, 16'hffff}, 1'b1,
      '{ST_CLAMPED, 16'h0000, 24'd4000000, 12'd2048, 4'd7, 14'd0, 9'd50, 6'd40, 6'd0}},
    '{'{ACT_APPLY, PID_MAX_TURN, 16'h0001}, 1'b1,
      '{ST_OK, 16'h0000, 24'd4000000, 12'd2048, 4'd7, 14'd0, 9'd500, 6'd40, 6'd0}},
    '{'{ACT_APPLY, PID_WINDOW, 16'h0000}, 1'b1,
      '{ST_EMPTY, 16'h0000, 24'd4000000, 12'd2048, 4'd0, 14'd0, 9'd500, 6'd40, 6'd0}},
    '{'{ACT_APPLY, PID_WINDOW, 16'hff80}, 1'b0, '0},
    '{'{ACT_APPLY, PID_DATA_SIZE, 16'h00c0}, 1'b0, '0},
    '{'{ACT_APPLY, PID_DATA_SIZE, 16'h0001}, 1'b0, '0},
    '{'{ACT_APPLY, PID_ADD_BOFS, 16'h0001}, 1'b0, '0},
    '{'{ACT_APPLY, PID_MIN_TURN, 16'h0001}, 1'b0, '0},
    '{'{ACT_APPLY, PID_LINK_DISC, 16'hff01}, 1'b0, '0},
    '{'{ACT_APPLY, PID_BAUD, 16'hfe01}, 1'b0, '0},
    '{'{ACT_APPLY, PID_BAUD, 16'h0000}, 1'b0, '0},
    '{'{ACT_GET, PID_BAUD, 16'h0000}, 1'b0, '0},
    '{'{ACT_GET, PID_LINK_DISC, 16'h0000}, 1'b0, '0},
    '{'{ACT_GET, PID_MAX_TURN, 16'h0000}, 1'b0, '0},
    '{'{ACT_GET, PID_DATA_SIZE, 16'h0000}, 1'b0, '0},
    '{'{ACT_GET, PID_WINDOW, 16'h0000}, 1'b0, '0},
    '{'{ACT_GET, PID_ADD_BOFS, 16'h0000}, 1'b0, '0},
    '{'{ACT_GET, PID_MIN_TURN, 16'h0000}, 1'b0, '0},
    '{'{ACT_GET, 8'h87, 16'hffff}, 1'b0, '0},
    '{'{ACT_START, 8'hff, 16'hffff}, 1'b1,
      '{ST_OK, 16'h0000, 24'd4000000, 12'd2048, 4'd7, 14'd0, 9'd50, 6'd40, 6'd0}}
  };

  loc_t loc;
  mask_t neg;
  rsp_t expected_qos [$];
  int errors = 0;
  bit calm = 1'b0;
  int stall_left = 0;
  int stuck = 0;

  function automatic void load_neg();
    neg.rx_baud = loc.baud;
    neg.tx_baud = loc.baud;
    neg.rx_link_disc = loc.ldisc;
    neg.tx_link_disc = loc.ldisc;
    neg.tx_window = loc.window;
    neg.tx_min_turn = loc.min_turn;
    neg.tx_max_turn = loc.max_turn;
    neg.tx_data_size = loc.dsize;
    neg.tx_add_bofs = loc.xbofs;
  endfunction

  function automatic int top_index(logic [15:0] m);
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) return i;
    end
    return -1;
  endfunction

  function automatic int table_pick(logic [15:0] m, int len, inout bit empty,
                                    inout bit clamp);
    int i;
    i = top_index(m);
    if (i < 0) begin
      empty = 1'b1;
    end else if (i >= len) begin
      clamp = 1'b1;
      i = len - 1;
    end
    return i;
  endfunction

  function automatic rsp_t negotiate(req_t r);
    rsp_t o;
    bit unknown;
    bit empty;
    bit clamp;
    int i;
    logic [7:0] b8;
    o = '0;
    unknown = 1'b0;
    empty = 1'b0;
    clamp = 1'b0;
    b8 = r.param_value[7:0];
    case (r.action)
      ACT_START: load_neg();
      ACT_APPLY: begin
        case (r.param_id)
          PID_BAUD: begin
            neg.rx_baud = neg.rx_baud & r.param_value;
            neg.tx_baud = neg.rx_baud;
          end
          PID_LINK_DISC: begin
            neg.rx_link_disc = neg.rx_link_disc & b8;
            neg.tx_link_disc = neg.rx_link_disc;
          end
          PID_MAX_TURN:  neg.tx_max_turn = b8;
          PID_DATA_SIZE: neg.tx_data_size = b8;
          PID_WINDOW:    neg.tx_window = b8;
          PID_ADD_BOFS:  neg.tx_add_bofs = b8;
          PID_MIN_TURN:  neg.tx_min_turn = b8;
          default:       unknown = 1'b1;
        endcase
      end
      ACT_GET: begin
        case (r.param_id)
          PID_BAUD:      o.param_bits_out = neg.rx_baud;
          PID_LINK_DISC: o.param_bits_out = {8'h00, neg.rx_link_disc};
          PID_MAX_TURN:  o.param_bits_out = {8'h00, loc.max_turn};
          PID_DATA_SIZE: o.param_bits_out = {8'h00, loc.dsize};
          PID_WINDOW:    o.param_bits_out = {8'h00, loc.window};
          PID_ADD_BOFS:  o.param_bits_out = {8'h00, loc.xbofs};
          PID_MIN_TURN:  o.param_bits_out = {8'h00, loc.min_turn};
          default:       unknown = 1'b1;
        endcase
      end
      default: ;
    endcase

    i = table_pick(neg.tx_baud, $size(baud_tab), empty, clamp);
    o.baud_rate_bps = (i < 0) ? 24'd0 : 24'(baud_tab[i]);
    i = table_pick({8'h00, neg.tx_data_size}, $size(data_tab), empty, clamp);
    o.data_size_bytes = (i < 0) ? 12'd0 : 12'(data_tab[i]);
    i = top_index({8'h00, neg.tx_window});
    if (i < 0) empty = 1'b1;
    o.window_frames = 4'(i + 1);
    i = table_pick({8'h00, neg.tx_min_turn}, $size(min_turn_tab), empty, clamp);
    o.min_turn_us = (i < 0) ? 14'd0 : 14'(min_turn_tab[i]);
    i = table_pick({8'h00, neg.tx_max_turn}, $size(max_turn_tab), empty, clamp);
    o.max_turn_ms = (i < 0) ? 9'd0 : 9'(max_turn_tab[i]);
    i = table_pick({8'h00, neg.tx_link_disc}, $size(disc_tab), empty, clamp);
    o.link_disc_s = (i < 0) ? 6'd0 : 6'(disc_tab[i]);
    i = table_pick({8'h00, neg.tx_add_bofs}, $size(bofs_tab), empty, clamp);
    o.extra_bofs = (i < 0) ? 6'd0 : 6'(bofs_tab[i]);

    o.status = unknown ? ST_UNKNOWN : empty ? ST_EMPTY : clamp ? ST_CLAMPED : ST_OK;
    return o;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] peer_value();
    case ($urandom_range(0, 2))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'(32'h1 << $urandom_range(0, 15));
      default: return 16'((32'h1 << $urandom_range(1, 16)) - 1);
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int k;
    k = $urandom_range(0, 99);
    r.param_value = peer_value();
    r.param_id = known_ids[$urandom_range(0, 6)];
    if (k < 8) begin
      r.action = ACT_START;
    end else if (k < 60) begin
      r.action = ACT_APPLY;
    end else if (k < 85) begin
      r.action = ACT_GET;
    end else begin
      r.action = k[0] ? ACT_APPLY : ACT_GET;
      r.param_id = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic send(input req_t r, input logic typed, input rsp_t typed_exp);
    int g;
    rsp_t p;
    g = calm ? 0 : idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = negotiate(r);
    expected_qos.push_back(typed ? typed_exp : p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_qos.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    case (idx)
      REG_BAUD:      loc.baud = d;
      REG_WINDOW:    loc.window = d[7:0];
      REG_MIN_TURN:  loc.min_turn = d[7:0];
      REG_MAX_TURN:  loc.max_turn = d[7:0];
      REG_DATA_SIZE: loc.dsize = d[7:0];
      REG_LINK_DISC: loc.ldisc = d[7:0];
      REG_ADD_BOFS:  loc.xbofs = d[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : receiver
    int g;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      g = calm ? 0 : idle_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        stall_left = g - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_qos.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_qos.pop_front();
        check_field("status", 32'(e.status), 32'(out_data.status));
        check_field("param_bits_out", 32'(e.param_bits_out),
                    32'(out_data.param_bits_out));
        check_field("baud_rate_bps", 32'(e.baud_rate_bps), 32'(out_data.baud_rate_bps));
        check_field("data_size_bytes", 32'(e.data_size_bytes),
                    32'(out_data.data_size_bytes));
        check_field("window_frames", 32'(e.window_frames), 32'(out_data.window_frames));
        check_field("min_turn_us", 32'(e.min_turn_us), 32'(out_data.min_turn_us));
        check_field("max_turn_ms", 32'(e.max_turn_ms), 32'(out_data.max_turn_ms));
        check_field("link_disc_s", 32'(e.link_disc_s), 32'(out_data.link_disc_s));
        check_field("extra_bofs", 32'(e.extra_bofs), 32'(out_data.extra_bofs));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] d;
    logic [CFG_IDX_W-1:0] idx;
    loc = '{RST_BAUD, RST_WINDOW, RST_MIN_TURN, RST_MAX_TURN, RST_DATA_SIZE,
            RST_LINK_DISC, RST_ADD_BOFS};
    load_neg();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(dir_tab); i++) begin
      send(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].exp);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        for (int i = 0; i < 7; i++) begin
          idx = CFG_IDX_W'(i);
          case (ph)
            1: d = 16'h0000;
            2: d = 16'hffff;
            3: begin
              case (idx)
                REG_BAUD:      d = RST_BAUD;
                REG_WINDOW:    d = {8'h00, RST_WINDOW};
                REG_MIN_TURN:  d = {8'h00, RST_MIN_TURN};
                REG_MAX_TURN:  d = {8'h00, RST_MAX_TURN};
                REG_DATA_SIZE: d = {8'h00, RST_DATA_SIZE};
                REG_LINK_DISC: d = {8'h00, RST_LINK_DISC};
                default:       d = {8'h00, RST_ADD_BOFS};
              endcase
            end
            default: d = 16'($urandom_range(0, 65535));
          endcase
          write_reg(idx, d);
        end
        if (ph > 3) write_reg(REG_NONE, 16'($urandom_range(0, 65535)));
        cfg_we <= 1'b0;
        send('{ACT_START, 8'h00, 16'h0000}, 1'b0, '0);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if (n == PHASE_ITEMS / 2) drain();
        send(random_request(), 1'b0, '0);
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_qos.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
